[design/btk_pkg.sv]
// ----------------------------------------------------------------------------
// btk_pkg
// Shared types and constants for the top-k smallest keeper: transaction
// payloads, command and status codes, and the control bundle sent to the cells.
// ----------------------------------------------------------------------------
package btk_pkg;

    localparam int KEY_BITS     = 32;
    localparam int TAG_BITS     = 16;
    localparam int LIMIT_BITS   = 7;
    localparam int CAPACITY_DEF = 64;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 7'd50;

    localparam int DATA_BITS = 32;
    localparam int ADDR_BITS = 3;

    // register index, taken from the word address
    localparam logic REG_KEEP_LIMIT = 1'b0;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DRAIN  = 1'b1;

    localparam logic [2:0] ST_ACCEPT = 3'd0;
    localparam logic [2:0] ST_EVICT  = 3'd1;
    localparam logic [2:0] ST_REJECT = 3'd2;
    localparam logic [2:0] ST_ENTRY  = 3'd3;
    localparam logic [2:0] ST_EMPTY  = 3'd4;

    typedef struct packed {
        logic                command;
        logic [KEY_BITS-1:0] key_in;
        logic [TAG_BITS-1:0] tag_in;
    } t_in_item;

    typedef struct packed {
        logic [2:0]          status;
        logic [KEY_BITS-1:0] key_out;
        logic [TAG_BITS-1:0] tag_out;
        logic                last;
    } t_out_item;

    typedef struct packed {
        logic insert;
        logic shift_out;
    } t_cell_ctrl;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_DRAIN = 2'b10
    } t_state;

endpackage

[design/btk_cell.sv]
// ----------------------------------------------------------------------------
// btk_cell
// One slot of the sorted chain. On insert it keeps its entry, takes the new
// key or takes its left neighbor; on drain it takes its right neighbor.
// ----------------------------------------------------------------------------
module btk_cell (
    input  logic                         i_clk,
    input  btk_pkg::t_cell_ctrl          i_ctrl,
    input  logic [btk_pkg::KEY_BITS-1:0] i_new_key,
    input  logic [btk_pkg::TAG_BITS-1:0] i_new_tag,
    input  logic [btk_pkg::KEY_BITS-1:0] i_left_key,
    input  logic [btk_pkg::TAG_BITS-1:0] i_left_tag,
    input  logic                         i_left_take,
    input  logic [btk_pkg::KEY_BITS-1:0] i_right_key,
    input  logic [btk_pkg::TAG_BITS-1:0] i_right_tag,
    input  logic                         i_occupied,
    output logic [btk_pkg::KEY_BITS-1:0] o_key,
    output logic [btk_pkg::TAG_BITS-1:0] o_tag,
    output logic                         o_ge,
    output logic                         o_take
);
    import btk_pkg::*;

    logic [KEY_BITS-1:0] r_key, n_key;
    logic [TAG_BITS-1:0] r_tag, n_tag;

    assign o_ge   = r_key >= i_new_key;
    // free slots count as larger, so the new key lands right after the last entry
    assign o_take = !i_occupied || o_ge;

    always_comb begin
        n_key = r_key;
        n_tag = r_tag;
        if (i_ctrl.insert) begin
            if (i_left_take) begin
                n_key = i_left_key;
                n_tag = i_left_tag;
            end else if (o_take) begin
                n_key = i_new_key;
                n_tag = i_new_tag;
            end
        end else if (i_ctrl.shift_out) begin
            n_key = i_right_key;
            n_tag = i_right_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_tag <= n_tag;
    end

    assign o_key = r_key;
    assign o_tag = r_tag;

endmodule

[design/bounded_top_k_smallest_keeper.sv]
// ----------------------------------------------------------------------------
// bounded_top_k_smallest_keeper
// Keeps the smallest keys seen in a sorted chain of cells, evicting the
// largest on overflow, and drains them in ascending order on command.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  in        input      i_in_valid / o_in_stall  t_in_item (command, key, tag)
//  out       output     o_out_valid / i_out_stall t_out_item (status, key, tag, last)
//  cfg       input      APB psel/penable/pwrite  keep_limit at byte address 0
//
//  On an insert every cell compares in parallel, the chain shifts right by one
//  slot, and the status shows in the output register in the next cycle.
//  A drain accepts the command, then shifts one entry per cycle out of the head
//  cell while the output is not stalled; no input is taken until the last entry
//  is loaded.
//  Reset empties the store and sets keep_limit to 50; the cells need no sweep.
//  A stalled output holds the input off once the output register is full.
// ----------------------------------------------------------------------------
module bounded_top_k_smallest_keeper #(
    parameter int CAPACITY = btk_pkg::CAPACITY_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  btk_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output btk_pkg::t_out_item            o_out_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [btk_pkg::ADDR_BITS-1:0] paddr,
    input  logic [btk_pkg::DATA_BITS-1:0] pwdata,
    output logic [btk_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready
);
    import btk_pkg::*;

    localparam int CNT_BITS = $clog2(CAPACITY + 1);

    t_state              r_state, n_state;
    logic [CNT_BITS-1:0] r_count, n_count;
    logic [CNT_BITS-1:0] r_left, n_left;
    logic [LIMIT_BITS-1:0] r_keep_limit;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out, n_out;

    logic [KEY_BITS-1:0] w_key  [CAPACITY];
    logic [TAG_BITS-1:0] w_tag  [CAPACITY];
    logic [CAPACITY-1:0] w_ge;
    logic [CAPACITY-1:0] w_take;
    logic [CAPACITY-1:0] w_occ;
    logic [CAPACITY-1:0] w_occ_full;

    logic                w_slot_free;
    logic                w_in_acc;
    logic                w_is_insert;
    logic [LIMIT_BITS-1:0] w_lim;
    logic                w_full;
    logic                w_hit;
    logic                w_reject;
    logic                w_evict;
    logic [CNT_BITS-1:0] w_ceff;
    t_cell_ctrl          w_ctrl;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_KEEP_LIMIT) ? DATA_BITS'(r_keep_limit) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_limit <= LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_KEEP_LIMIT) begin
            r_keep_limit <= pwdata[LIMIT_BITS-1:0];
        end
    end

    // zero acts as one, above capacity acts as capacity
    always_comb begin
        if (r_keep_limit == '0) begin
            w_lim = LIMIT_BITS'(1);
        end else if (r_keep_limit > LIMIT_BITS'(CAPACITY)) begin
            w_lim = LIMIT_BITS'(CAPACITY);
        end else begin
            w_lim = r_keep_limit;
        end
    end

    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !(r_state == S_IDLE && w_slot_free);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_is_insert = i_in_item.command == CMD_INSERT;

    assign w_full   = LIMIT_BITS'(r_count) >= w_lim;
    // sorted chain: some entry is >= the key exactly when the largest one is
    assign w_hit    = |(w_ge & w_occ_full);
    assign w_reject = w_full && !w_hit;
    assign w_evict  = w_full && w_hit;
    assign w_ceff   = w_evict ? r_count - CNT_BITS'(1) : r_count;

    assign w_ctrl.insert    = w_in_acc && w_is_insert && !w_reject;
    assign w_ctrl.shift_out = r_state == S_DRAIN && w_slot_free;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign w_occ[g]      = CNT_BITS'(g) < w_ceff;
        assign w_occ_full[g] = CNT_BITS'(g) < r_count;

        btk_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_new_key   (i_in_item.key_in),
            .i_new_tag   (i_in_item.tag_in),
            .i_left_key  ((g == 0) ? i_in_item.key_in : w_key[(g == 0) ? 0 : g - 1]),
            .i_left_tag  ((g == 0) ? i_in_item.tag_in : w_tag[(g == 0) ? 0 : g - 1]),
            .i_left_take ((g == 0) ? 1'b0 : w_take[(g == 0) ? 0 : g - 1]),
            .i_right_key (w_key[(g == CAPACITY - 1) ? g : g + 1]),
            .i_right_tag (w_tag[(g == CAPACITY - 1) ? g : g + 1]),
            .i_occupied  (w_occ[g]),
            .o_key       (w_key[g]),
            .o_tag       (w_tag[g]),
            .o_ge        (w_ge[g]),
            .o_take      (w_take[g])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_left      = r_left;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_out_valid = 1'b1;
                    n_out       = '{status: ST_ACCEPT, key_out: '0, tag_out: '0, last: 1'b1};
                    if (w_is_insert) begin
                        if (w_reject) begin
                            n_out.status = ST_REJECT;
                        end else if (w_evict) begin
                            n_out.status = ST_EVICT;
                        end else begin
                            n_count = r_count + CNT_BITS'(1);
                        end
                    end else if (r_count == '0) begin
                        n_out.status = ST_EMPTY;
                    end else begin
                        n_out_valid = 1'b0;
                        n_out       = r_out;
                        n_left      = r_count;
                        n_state     = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{status: ST_ENTRY, key_out: w_key[0], tag_out: w_tag[0],
                                    last: r_left == CNT_BITS'(1)};
                    n_left      = r_left - CNT_BITS'(1);
                    if (r_left == CNT_BITS'(1)) begin
                        n_count = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // an insert always answers with a single marked result next cycle
    a_insert_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_is_insert) |=> (o_out_valid && o_out_item.last))
        else $error("insert did not produce a result");

    // loading the final drained entry empties the store
    a_drain_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN && w_slot_free && r_left == CNT_BITS'(1))
        |=> (r_count == '0 && o_out_valid && o_out_item.last
             && o_out_item.status == ST_ENTRY && r_state == S_IDLE))
        else $error("drain end did not clear the store");

    // the fill count moves only on an accepted transaction or a drain
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_in_acc && r_state == S_IDLE) |=> $stable(r_count))
        else $error("fill count changed while idle");

endmodule

[dv/top_k_keeper_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// top_k_keeper_checker
// Watches the input, output and register channels of the top-k smallest
// keeper. It keeps its own sorted copy of the store, predicts the status and
// drained entries for every input transaction, and compares each output
// transaction in order. It reports the failure count and the results still
// awaited.
// ----------------------------------------------------------------------------
module top_k_keeper_checker #(
    parameter int CAPACITY = btk_pkg::CAPACITY_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  btk_pkg::t_in_item             i_in_item,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  btk_pkg::t_out_item            i_out_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [btk_pkg::ADDR_BITS-1:0] paddr,
    input  logic [btk_pkg::DATA_BITS-1:0] pwdata,
    input  logic                          pready,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_checked
);
    import btk_pkg::*;

    logic [KEY_BITS-1:0]   kept_key [CAPACITY];
    logic [TAG_BITS-1:0]   kept_tag [CAPACITY];
    int                    kept_count;
    logic [LIMIT_BITS-1:0] keep_limit;
    t_out_item             awaited_results [$];
    int                    fail_count = 0;
    int                    checked    = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = awaited_results.size();
    assign o_checked    = checked;

    function automatic t_out_item make_result(input logic [2:0] status,
                                              input logic [KEY_BITS-1:0] key,
                                              input logic [TAG_BITS-1:0] tag,
                                              input logic last);
        t_out_item res;
        res.status  = status;
        res.key_out = key;
        res.tag_out = tag;
        res.last    = last;
        return res;
    endfunction

    task automatic predict_outcome(input t_in_item item);
        int         lim;
        int         pos;
        logic [2:0] status;
        lim    = int'(keep_limit);
        status = ST_ACCEPT;
        if (lim == 0) begin
            lim = 1;
        end
        if (lim > CAPACITY) begin
            lim = CAPACITY;
        end
        if (item.command == CMD_DRAIN) begin
            if (kept_count == 0) begin
                awaited_results.push_back(make_result(ST_EMPTY, '0, '0, 1'b1));
            end else begin
                for (int i = 0; i < kept_count; i++) begin
                    awaited_results.push_back(make_result(ST_ENTRY, kept_key[i], kept_tag[i],
                                                          i == kept_count - 1));
                end
                kept_count = 0;
            end
            return;
        end
        // full store, possibly because the limit was lowered under the count
        if (kept_count >= lim && kept_count > 0) begin
            if (item.key_in > kept_key[kept_count-1]) begin
                awaited_results.push_back(make_result(ST_REJECT, '0, '0, 1'b1));
                return;
            end
            kept_count--;
            status = ST_EVICT;
        end
        // newer key goes ahead of equal older keys
        pos = kept_count;
        for (int i = 0; i < kept_count; i++) begin
            if (kept_key[i] >= item.key_in) begin
                pos = i;
                break;
            end
        end
        for (int i = kept_count; i > pos; i--) begin
            kept_key[i] = kept_key[i-1];
            kept_tag[i] = kept_tag[i-1];
        end
        kept_key[pos] = item.key_in;
        kept_tag[pos] = item.tag_in;
        kept_count++;
        awaited_results.push_back(make_result(status, '0, '0, 1'b1));
    endtask

    task automatic compare_result(input t_out_item got);
        t_out_item exp;
        if (awaited_results.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result status=%0d key=%h tag=%h last=%b",
                     $realtime, got.status, got.key_out, got.tag_out, got.last);
            return;
        end
        exp = awaited_results.pop_front();
        checked++;
        if (got.status !== exp.status) begin
            fail_count++;
            $display("%0t: status expected %0d actual %0d", $realtime, exp.status, got.status);
        end
        if (got.key_out !== exp.key_out) begin
            fail_count++;
            $display("%0t: key expected %h actual %h", $realtime, exp.key_out, got.key_out);
        end
        if (got.tag_out !== exp.tag_out) begin
            fail_count++;
            $display("%0t: tag expected %h actual %h", $realtime, exp.tag_out, got.tag_out);
        end
        if (got.last !== exp.last) begin
            fail_count++;
            $display("%0t: last expected %b actual %b", $realtime, exp.last, got.last);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            kept_count = 0;
            keep_limit = LIMIT_RESET;
            awaited_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                compare_result(i_out_item);
            end
            if (i_in_valid && !i_in_stall) begin
                predict_outcome(i_in_item);
            end
            if (psel && penable && pwrite && pready && paddr[2] == REG_KEEP_LIMIT) begin
                keep_limit = pwdata[LIMIT_BITS-1:0];
            end
        end
    end

endmodule

[dv/bounded_top_k_smallest_keeper_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_top_k_smallest_keeper_test
// Drives inserts and drains into the top-k smallest keeper under random
// idling on both channels and several keep_limit settings, including zero,
// one, the full capacity and above it. A checker beside the block predicts
// every status and drained entry; this module decides pass or fail.
// ----------------------------------------------------------------------------
module bounded_top_k_smallest_keeper_test;
    import btk_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_item   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_item;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [ADDR_BITS-1:0] paddr       = '0;
    logic [DATA_BITS-1:0] pwdata      = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    int fail_count;
    int pending;
    int checked;
    int cycles         = 0;
    int inserts_sent   = 0;
    int drains_sent    = 0;
    int limit_settings = 0;
    bit idle_on        = 1'b1;
    bit stall_on       = 1'b1;

    bounded_top_k_smallest_keeper i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    top_k_keeper_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= stall_on && ($urandom_range(99) < 31);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic push_command(input t_in_item item);
        // valid drops once and stays low for the whole idle stretch
        if (idle_on && $urandom_range(99) < 31) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while (idle_on && $urandom_range(99) < 31);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic insert_key(input logic [KEY_BITS-1:0] key, input logic [TAG_BITS-1:0] tag);
        t_in_item item;
        item.command = CMD_INSERT;
        item.key_in  = key;
        item.tag_in  = tag;
        push_command(item);
        inserts_sent++;
    endtask

    task automatic drain_store();
        t_in_item item;
        item.command = CMD_DRAIN;
        item.key_in  = $urandom;
        item.tag_in  = TAG_BITS'($urandom_range(16'hffff));
        push_command(item);
        drains_sent++;
    endtask

    // hold the sender until every awaited result is out, then a short margin
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_keep_limit(input logic [LIMIT_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_KEEP_LIMIT, 2'b00};
        pwdata  <= DATA_BITS'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        limit_settings++;
    endtask

    // extremes and a narrow set of values so that ties are common
    function automatic logic [KEY_BITS-1:0] pick_key();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return KEY_BITS'($urandom_range(7)) << 28;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [LIMIT_BITS-1:0] phase_limit [7] = '{7'd127, 7'd1, 7'd0, 7'd5, 7'd64, 7'd17, 7'd50};
        int                    phase_items [7] = '{75, 20, 15, 30, 25, 20, 20};
        int                    drain_odds;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset limit: empty drain, extreme keys and ties
        drain_store();
        insert_key('0, 16'h0000);
        insert_key('1, 16'hffff);
        insert_key(32'h8000_0000, 16'h5555);
        insert_key(32'h8000_0000, 16'haaaa);
        drain_store();
        wait_for_results();

        // single entry: equal key evicts, larger key is rejected
        set_keep_limit(7'd1);
        insert_key(32'h4000_0000, 16'h0001);
        insert_key(32'h4000_0000, 16'h0002);
        insert_key(32'h4000_0001, 16'h0003);
        insert_key('0, 16'h0004);
        drain_store();
        wait_for_results();

        // zero limit behaves as one
        set_keep_limit(7'd0);
        insert_key('1, 16'h0005);
        insert_key('1, 16'h0006);
        drain_store();
        wait_for_results();

        // lower the limit under the current count
        set_keep_limit(7'd8);
        repeat (8) insert_key(pick_key(), TAG_BITS'($urandom_range(16'hffff)));
        wait_for_results();
        set_keep_limit(7'd3);
        insert_key('0, 16'h0007);
        insert_key('1, 16'h0008);
        drain_store();
        wait_for_results();

        for (int p = 0; p < 7; p++) begin
            set_keep_limit(phase_limit[p]);
            // first phase runs back to back and fills the whole store
            idle_on    = (p != 0);
            stall_on   = (p != 0);
            drain_odds = (p == 0) ? 100 : 12;
            for (int n = 0; n < phase_items[p]; n++) begin
                if ($urandom_range(drain_odds - 1) == 0) begin
                    drain_store();
                end else begin
                    insert_key(pick_key(), TAG_BITS'($urandom_range(16'hffff)));
                end
            end
            wait_for_results();
        end
        drain_store();
        wait_for_results();

        $display("run covered %0d inserts and %0d drains across %0d keep_limit writes",
                 inserts_sent, drains_sent, limit_settings);
        $display("%0d results compared in %0d cycles", checked, cycles);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d failures, %0d results never arrived", fail_count, pending);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
